// ===== rtl/core/escu_pkg.sv =====
`timescale 1ns / 1ps

package escu_pkg;

	// floor and bit index widths fixed by the 6-bit signed floor numbering
	localparam int FLOOR_W   = 6;
	localparam int IDX_W     = 6;
	localparam int FLOOR_SPAN = 64;
	localparam int CFG_IDX_W = 1;

	localparam logic signed [FLOOR_W-1:0] FLOOR_LO = -6'sd32;
	localparam logic signed [FLOOR_W-1:0] FLOOR_HI = 6'sd31;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FLOOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLOOR = 1'b1;

	// input item kinds
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// floor f sits at bit f + 32: flip the sign bit
	function automatic logic [IDX_W-1:0] floor_to_idx(input logic signed [FLOOR_W-1:0] f);
		floor_to_idx = {~f[FLOOR_W-1], f[FLOOR_W-2:0]};
	endfunction

endpackage

// ===== rtl/core/escu_req_if.sv =====
`timescale 1ns / 1ps

interface escu_req_if import escu_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [FLOOR_W-1:0] floor;

	modport source (output valid, output kind, output floor, input ready);
	modport sink   (input valid, input kind, input floor, output ready);
endinterface

// ===== rtl/core/escu_res_if.sv =====
`timescale 1ns / 1ps

interface escu_res_if import escu_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FLOOR_W-1:0] car_floor;
	logic [1:0]                travel_dir;
	logic                      is_idle;
	logic                      served_stop;

	modport source (output valid, output car_floor, output travel_dir, output is_idle,
		output served_stop, input ready);
	modport sink   (input valid, input car_floor, input travel_dir, input is_idle,
		input served_stop, output ready);
endinterface

// ===== rtl/core/escu_decide.sv =====
`timescale 1ns / 1ps

// SCAN heading decision over the pending bitmap
module escu_decide import escu_pkg::*; #(
	parameter int BITS = 64
) (
	input  logic [BITS-1:0]  pend,
	input  logic [IDX_W-1:0] pidx,
	input  dir_t             head,
	output dir_t             head_next
);

	localparam int CMP_W = IDX_W + 1;

	logic [BITS-1:0]  ge_mask;
	logic [BITS-1:0]  gt_mask;
	logic             any_pend;
	logic             any_above;
	logic             any_below;
	logic             has_up;
	logic             has_dn;
	logic [IDX_W-1:0] up_idx;
	logic [IDX_W-1:0] dn_idx;
	logic [IDX_W-1:0] dist_up;
	logic [IDX_W-1:0] dist_dn;

	// position masks
	always_comb begin
		for (int i = 0; i < BITS; i++) begin
			ge_mask[i] = CMP_W'(i) >= {1'b0, pidx};
			gt_mask[i] = CMP_W'(i) > {1'b0, pidx};
		end
	end

	assign any_pend  = |pend;
	assign any_above = |(pend & gt_mask);
	assign any_below = |(pend & ~ge_mask);
	assign has_up    = |(pend & ge_mask);
	assign has_dn    = any_below;

	// nearest pending floor at or above, and strictly below, the car
	always_comb begin
		up_idx = '0;
		dn_idx = '0;
		for (int i = BITS - 1; i >= 0; i--) begin
			if (pend[i] && ge_mask[i]) begin
				up_idx = IDX_W'(i);
			end
		end
		for (int i = 0; i < BITS; i++) begin
			if (pend[i] && !ge_mask[i]) begin
				dn_idx = IDX_W'(i);
			end
		end
	end

	assign dist_up = up_idx - pidx;
	assign dist_dn = pidx - dn_idx;

	// keep heading while work lies ahead, else reverse or stop; from idle, go toward the nearer pending floor, up on a tie
	always_comb begin
		head_next = DIR_IDLE;
		if (any_pend) begin
			unique case (head)
				DIR_UP: begin
					head_next = any_above ? DIR_UP : (any_below ? DIR_DOWN : DIR_IDLE);
				end
				DIR_DOWN: begin
					head_next = any_below ? DIR_DOWN : (any_above ? DIR_UP : DIR_IDLE);
				end
				default: begin
					if (has_up && has_dn) begin
						head_next = (dist_up <= dist_dn) ? DIR_UP : DIR_DOWN;
					end else if (has_up) begin
						head_next = DIR_UP;
					end else begin
						head_next = DIR_DOWN;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/elevator_scan_controller_unit.sv =====
`timescale 1ns / 1ps
// an accepted request or tick has its result in the output register in the next cycle; one
// transaction per cycle unless the output stalls; the full state update (bitmap, floor,
// heading) is one pass of priority logic over the pending bitmap between state registers
// reset (arst_n low, asynchronous): no floor pending, car at floor 0, heading idle,
// floor range -32..31, output register empty

module elevator_scan_controller_unit import escu_pkg::*; #(
	parameter int FLOOR_COUNT = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	escu_req_if.sink                    req,
	escu_res_if.source                  res,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_idx,
	input  logic signed [FLOOR_W-1:0]   cfg_wdata
);

	// floors at index FLOOR_COUNT and up, or beyond the 6-bit range, never get a bit
	localparam int BITS = (FLOOR_COUNT < FLOOR_SPAN) ? FLOOR_COUNT : FLOOR_SPAN;

	logic signed [FLOOR_W-1:0] min_q;
	logic signed [FLOOR_W-1:0] max_q;
	logic [BITS-1:0]           pend_q;
	logic signed [FLOOR_W-1:0] pos_q;
	dir_t                      head_q;

	logic                      res_valid_q;
	logic signed [FLOOR_W-1:0] res_floor_q;
	dir_t                      res_dir_q;
	logic                      res_idle_q;
	logic                      res_served_q;

	logic                      accept;
	logic [FLOOR_SPAN-1:0]     req_hot;
	logic [FLOOR_SPAN-1:0]     move_hot;
	logic [FLOOR_SPAN-1:0]     pos_hot;
	logic                      req_ok;
	logic signed [FLOOR_W-1:0] pos_next;
	logic [BITS-1:0]           pend_next;
	logic                      served;
	logic [IDX_W-1:0]          dec_pidx;
	dir_t                      dec_head;
	dir_t                      head_next;

	assign req.ready = !res_valid_q || res.ready;
	assign accept    = req.valid && req.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= FLOOR_LO;
			max_q <= FLOOR_HI;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MIN_FLOOR: min_q <= cfg_wdata;
				default:       max_q <= cfg_wdata;
			endcase
		end
	end

	// one-hot decodes of the requested floor and the car floor
	assign req_hot = FLOOR_SPAN'(1) << floor_to_idx(req.floor);
	assign pos_hot = FLOOR_SPAN'(1) << floor_to_idx(pos_q);

	assign req_ok = (req.floor >= min_q) && (req.floor <= max_q) && (req.floor != pos_q)
		&& (|req_hot[BITS-1:0]);

	// next car floor
	always_comb begin
		pos_next = pos_q;
		if (req.kind == KIND_TICK && (|pend_q)) begin
			if (head_q == DIR_UP && pos_q != FLOOR_HI) begin
				pos_next = pos_q + FLOOR_W'(1);
			end else if (head_q == DIR_DOWN && pos_q != FLOOR_LO) begin
				pos_next = pos_q - FLOOR_W'(1);
			end
		end
	end

	assign move_hot = FLOOR_SPAN'(1) << floor_to_idx(pos_next);

	// next bitmap and served flag
	always_comb begin
		pend_next = pend_q;
		served    = 1'b0;
		if (req.kind == KIND_REQUEST) begin
			if (req_ok) begin
				pend_next = pend_q | req_hot[BITS-1:0];
			end
		end else if (|pend_q) begin
			served    = |(pend_q & move_hot[BITS-1:0]);
			pend_next = pend_q & ~move_hot[BITS-1:0];
		end
	end

	assign dec_pidx = floor_to_idx(pos_next);
	assign dec_head = head_q;

	escu_decide #(
		.BITS (BITS)
	) u_decide (
		.pend      (pend_next),
		.pidx      (dec_pidx),
		.head      (dec_head),
		.head_next (head_next)
	);

	// car state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pos_q  <= '0;
			head_q <= DIR_IDLE;
		end else if (accept) begin
			pend_q <= pend_next;
			pos_q  <= pos_next;
			if (req.kind == KIND_TICK || req_ok) begin
				head_q <= head_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_floor_q  <= pos_next;
			res_dir_q    <= (req.kind == KIND_TICK || req_ok) ? head_next : head_q;
			res_idle_q   <= !(|pend_next)
				&& (((req.kind == KIND_TICK || req_ok) ? head_next : head_q) == DIR_IDLE);
			res_served_q <= served;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.car_floor   = res_floor_q;
	assign res.travel_dir  = res_dir_q;
	assign res.is_idle     = res_idle_q;
	assign res.served_stop = res_served_q;

`ifndef ASSERT_OFF
	// the floor the car stands on is never left pending
	a_no_pending_at_car: assert property (@(posedge clk) disable iff (!arst_n)
		!(|(pend_q & pos_hot[BITS-1:0])))
		else $error("pending floor at car position");

	// heading is idle exactly when nothing is pending
	a_idle_iff_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == DIR_IDLE) == (pend_q == '0))
		else $error("heading and bitmap disagree");

	// the car moves only on an accepted tick
	a_move_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && req.kind == KIND_TICK) |=> $stable(pos_q))
		else $error("car moved without a tick");

	// a served stop only comes from a tick
	a_served_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == KIND_REQUEST) |=> !res_served_q)
		else $error("request reported a served stop");
`endif

endmodule
